// ===== design/pcc_pkg.sv =====
// ----------------------------------------------------------------------------
// pcc_pkg - shared types and constants of the clamped pid controller
// widths, register codes, the work request between front and back, config
// ----------------------------------------------------------------------------
package pcc_pkg;

  localparam int ERROR_WIDTH    = 16;
  localparam int FRAC_BITS      = 8;
  localparam int INTEGRAL_WIDTH = 24;

  localparam int GAIN_W  = 16;
  localparam int DRIVE_W = 16;
  localparam int DERIV_W = ERROR_WIDTH + 1;

  // widest config register sets the write data width
  localparam int CFG_DATA_W  = (INTEGRAL_WIDTH > GAIN_W) ? INTEGRAL_WIDTH : GAIN_W;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_CAP = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_MAX    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_MIN    = 3'd5;

  // integral update sum, one bit above the wider operand
  localparam int ISUM_W = ((INTEGRAL_WIDTH > ERROR_WIDTH) ? INTEGRAL_WIDTH : ERROR_WIDTH) + 1;

  // product and drive sum widths
  localparam int PE_W  = GAIN_W + ERROR_WIDTH;
  localparam int PI_W  = GAIN_W + INTEGRAL_WIDTH;
  localparam int PD_W  = GAIN_W + DERIV_W;
  localparam int PMAX_W = (PI_W > PE_W) ? ((PI_W > PD_W) ? PI_W : PD_W)
                                        : ((PE_W > PD_W) ? PE_W : PD_W);
  localparam int SUM_W = PMAX_W + 2;

  // work queue between front and back, result queue in the back
  localparam int WQ_DEPTH = 2;
  localparam int WQ_PTR_W = (WQ_DEPTH > 1) ? $clog2(WQ_DEPTH) : 1;
  localparam int WQ_CNT_W = $clog2(WQ_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);
  localparam int OCC_W    = $clog2(OQ_DEPTH + 2);

  localparam logic signed [INTEGRAL_WIDTH-1:0] CAP_RESET =
    {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX_RESET = {1'b0, {(DRIVE_W-1){1'b1}}};
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN_RESET = {1'b1, {(DRIVE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [GAIN_W-1:0]         gain_p;
    logic signed [GAIN_W-1:0]         gain_i;
    logic signed [GAIN_W-1:0]         gain_d;
    logic signed [INTEGRAL_WIDTH-1:0] integral_cap;
    logic signed [DRIVE_W-1:0]        drive_max;
    logic signed [DRIVE_W-1:0]        drive_min;
  } cfg_t;

  // one classified request, ready for the multiply stage
  typedef struct packed {
    logic signed [ERROR_WIDTH-1:0]    err;
    logic signed [INTEGRAL_WIDTH-1:0] integ;
    logic signed [DERIV_W-1:0]        deriv;
  } work_t;

  typedef struct packed {
    logic [OCC_W-1:0] occupancy;
    logic             issue;
  } back_status_t;

endpackage

// ===== design/pid_controller_clamped_top.sv =====
// ----------------------------------------------------------------------------
// pid_controller_clamped_top - clamped fixed point pid controller
// one error sample in, one clamped drive out, integral capped from above
// ----------------------------------------------------------------------------
// path: an accepted request is written to the work queue, then to the
//   multiply register, then to the result queue, whose head is out_drive
// throughput: one request per cycle while in_full is low; the loop state
//   (integral, last error) is updated at intake, the multipliers are one stage
// reset: synchronous, active low; clears integral, last error and all queues
//   and loads the register reset values; no clearing pass, ready at once
module pid_controller_clamped_top (
  input  logic                                      clk,
  input  logic                                      rst_n,
  // request side
  input  logic                                      in_push,
  output logic                                      in_full,
  input  logic signed [pcc_pkg::ERROR_WIDTH-1:0]    in_error_sample,
  input  logic                                      in_clear_first,
  // result side
  output logic                                      out_empty,
  input  logic                                      out_pop,
  output logic signed [pcc_pkg::DRIVE_W-1:0]        out_drive,
  // register writes
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [pcc_pkg::CFG_INDEX_W-1:0]           cfg_index,
  input  logic [pcc_pkg::CFG_DATA_W-1:0]            cfg_data
);

  pcc_pkg::cfg_t          cfg_r, cfg_nxt;
  pcc_pkg::work_t         front_work;
  pcc_pkg::work_t         q_work;
  pcc_pkg::back_status_t  back_st;
  logic                   in_accept;
  logic                   q_full;
  logic                   q_empty;
  logic                   q_pop;

  // register file: always ready, writes to unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pcc_pkg::REG_GAIN_P:       cfg_nxt.gain_p       = pcc_pkg::GAIN_W'(cfg_data);
        pcc_pkg::REG_GAIN_I:       cfg_nxt.gain_i       = pcc_pkg::GAIN_W'(cfg_data);
        pcc_pkg::REG_GAIN_D:       cfg_nxt.gain_d       = pcc_pkg::GAIN_W'(cfg_data);
        pcc_pkg::REG_INTEGRAL_CAP: cfg_nxt.integral_cap =
                                     pcc_pkg::INTEGRAL_WIDTH'(cfg_data);
        pcc_pkg::REG_DRIVE_MAX:    cfg_nxt.drive_max    = pcc_pkg::DRIVE_W'(cfg_data);
        pcc_pkg::REG_DRIVE_MIN:    cfg_nxt.drive_min    = pcc_pkg::DRIVE_W'(cfg_data);
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p       <= '0;
      cfg_r.gain_i       <= '0;
      cfg_r.gain_d       <= '0;
      cfg_r.integral_cap <= pcc_pkg::CAP_RESET;
      cfg_r.drive_max    <= pcc_pkg::DRIVE_MAX_RESET;
      cfg_r.drive_min    <= pcc_pkg::DRIVE_MIN_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // intake stalls only when the work queue is full
  assign in_full   = q_full;
  assign in_accept = in_push && !q_full;

  // front: clear, integral update, derivative
  pcc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .accept      (in_accept),
    .err         (in_error_sample),
    .clear_first (in_clear_first),
    .work        (front_work)
  );

  // decouples intake from the multiply side
  pcc_queue u_work_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_accept),
    .wr_data (front_work),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_work)
  );

  // back: products, scaling, clamps, result queue
  pcc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .work_empty (q_empty),
    .work       (q_work),
    .work_pop   (q_pop),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_drive  (out_drive),
    .status     (back_st)
  );

  // the back never issues from an empty work queue
  a_issue_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("back issued without a queued request");

  // reserved result slots never exceed the result queue
  a_no_oq_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    back_st.occupancy <= pcc_pkg::OCC_W'(pcc_pkg::OQ_DEPTH))
    else $error("result queue overrun");

  // reset leaves both queues empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && q_empty))
    else $error("queues not empty after reset");

  // an issued request reaches an idle result queue via the multiply register
  a_issue_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (back_st.issue && out_empty && !$past(back_st.issue)) |-> ##2 !out_empty)
    else $error("issued request did not reach the result queue");

endmodule

// ===== design/pcc_queue.sv =====
// ----------------------------------------------------------------------------
// pcc_queue - short work request queue between front and back
// flop based circular buffer, registered pointers and count
// ----------------------------------------------------------------------------
module pcc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pcc_pkg::work_t wr_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output pcc_pkg::work_t rd_data
);

  pcc_pkg::work_t                  mem_r [pcc_pkg::WQ_DEPTH];
  logic [pcc_pkg::WQ_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [pcc_pkg::WQ_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [pcc_pkg::WQ_CNT_W-1:0]    count_r, count_nxt;
  logic                            do_push, do_pop;

  assign full    = (count_r == pcc_pkg::WQ_CNT_W'(pcc_pkg::WQ_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == pcc_pkg::WQ_PTR_W'(pcc_pkg::WQ_DEPTH - 1)) ? '0
                   : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == pcc_pkg::WQ_PTR_W'(pcc_pkg::WQ_DEPTH - 1)) ? '0
                   : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== design/pcc_front.sv =====
// ----------------------------------------------------------------------------
// pcc_front - request intake and loop state update
// applies clear, updates integral and last error, forms the derivative
// ----------------------------------------------------------------------------
module pcc_front (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  pcc_pkg::cfg_t                            cfg,
  input  logic                                     accept,
  input  logic signed [pcc_pkg::ERROR_WIDTH-1:0]   err,
  input  logic                                     clear_first,
  output pcc_pkg::work_t                           work
);

  localparam logic signed [pcc_pkg::ISUM_W-1:0] ILOW =
    pcc_pkg::ISUM_W'($signed({1'b1, {(pcc_pkg::INTEGRAL_WIDTH-1){1'b0}}}));

  logic signed [pcc_pkg::INTEGRAL_WIDTH-1:0] integ_r, integ_nxt;
  logic signed [pcc_pkg::ERROR_WIDTH-1:0]    prev_r, prev_nxt;
  logic signed [pcc_pkg::INTEGRAL_WIDTH-1:0] integ_base;
  logic signed [pcc_pkg::ERROR_WIDTH-1:0]    prev_base;
  logic signed [pcc_pkg::ISUM_W-1:0]         isum;
  logic signed [pcc_pkg::ISUM_W-1:0]         isum_sat;
  logic                                      grow;

  always_comb begin
    integ_base = clear_first ? '0 : integ_r;
    prev_base  = clear_first ? '0 : prev_r;
    grow       = (cfg.gain_i != '0) && (integ_base < cfg.integral_cap);
    isum       = pcc_pkg::ISUM_W'(integ_base);
    if (grow) begin
      isum = pcc_pkg::ISUM_W'(integ_base) + pcc_pkg::ISUM_W'(err);
    end
    // cap from above, then saturate at the register width from below
    isum_sat = isum;
    if (isum_sat > pcc_pkg::ISUM_W'(cfg.integral_cap)) begin
      isum_sat = pcc_pkg::ISUM_W'(cfg.integral_cap);
    end
    if (isum_sat < ILOW) begin
      isum_sat = ILOW;
    end
    work.err   = err;
    work.integ = pcc_pkg::INTEGRAL_WIDTH'(isum_sat);
    work.deriv = pcc_pkg::DERIV_W'(err) - pcc_pkg::DERIV_W'(prev_base);
    integ_nxt  = accept ? work.integ : integ_r;
    prev_nxt   = accept ? err : prev_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      prev_r  <= '0;
    end else begin
      integ_r <= integ_nxt;
      prev_r  <= prev_nxt;
    end
  end

endmodule

// ===== design/pcc_back.sv =====
// ----------------------------------------------------------------------------
// pcc_back - gain multiply, sum, scale and clamp, result queue
// issues a request only when the result queue has a slot reserved for it
// ----------------------------------------------------------------------------
module pcc_back (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  pcc_pkg::cfg_t                          cfg,
  input  logic                                   work_empty,
  input  pcc_pkg::work_t                         work,
  output logic                                   work_pop,
  input  logic                                   out_pop,
  output logic                                   out_empty,
  output logic signed [pcc_pkg::DRIVE_W-1:0]     out_drive,
  output pcc_pkg::back_status_t                  status
);

  logic                                    v1_r, v1_nxt;
  logic signed [pcc_pkg::PE_W-1:0]         pe_r, pe_nxt;
  logic signed [pcc_pkg::PI_W-1:0]         pi_r, pi_nxt;
  logic signed [pcc_pkg::PD_W-1:0]         pd_r, pd_nxt;
  logic signed [pcc_pkg::SUM_W-1:0]        sum;
  logic signed [pcc_pkg::SUM_W-1:0]        scaled;
  logic signed [pcc_pkg::SUM_W-1:0]        clamped;
  logic signed [pcc_pkg::DRIVE_W-1:0]      drive;

  logic signed [pcc_pkg::DRIVE_W-1:0]      oq_mem_r [pcc_pkg::OQ_DEPTH];
  logic [pcc_pkg::OQ_PTR_W-1:0]            oq_wr_r, oq_wr_nxt;
  logic [pcc_pkg::OQ_PTR_W-1:0]            oq_rd_r, oq_rd_nxt;
  logic [pcc_pkg::OQ_CNT_W-1:0]            oq_cnt_r, oq_cnt_nxt;
  logic [pcc_pkg::OCC_W-1:0]               occupancy;
  logic                                    oq_pop;

  // queued results plus the one in the multiply stage
  assign occupancy = pcc_pkg::OCC_W'(oq_cnt_r) + pcc_pkg::OCC_W'(v1_r);
  assign work_pop  = !work_empty && (occupancy < pcc_pkg::OCC_W'(pcc_pkg::OQ_DEPTH));
  assign status.occupancy = occupancy;
  assign status.issue     = work_pop;

  // stage 1: products
  always_comb begin
    v1_nxt = work_pop;
    pe_nxt = work.err * cfg.gain_p;
    pi_nxt = work.integ * cfg.gain_i;
    pd_nxt = work.deriv * cfg.gain_d;
  end

  always_ff @(posedge clk) begin
    pe_r <= pe_nxt;
    pi_r <= pi_nxt;
    pd_r <= pd_nxt;
  end

  // stage 2: sum, floor shift, clamp max then min
  always_comb begin
    sum     = pcc_pkg::SUM_W'(pe_r) + pcc_pkg::SUM_W'(pi_r) + pcc_pkg::SUM_W'(pd_r);
    scaled  = sum >>> pcc_pkg::FRAC_BITS;
    clamped = scaled;
    if (clamped > pcc_pkg::SUM_W'(cfg.drive_max)) begin
      clamped = pcc_pkg::SUM_W'(cfg.drive_max);
    end
    if (clamped < pcc_pkg::SUM_W'(cfg.drive_min)) begin
      clamped = pcc_pkg::SUM_W'(cfg.drive_min);
    end
    drive = pcc_pkg::DRIVE_W'(clamped);
  end

  // result queue
  assign out_empty = (oq_cnt_r == '0);
  assign out_drive = oq_mem_r[oq_rd_r];
  assign oq_pop    = out_pop && !out_empty;

  always_comb begin
    oq_wr_nxt  = oq_wr_r;
    oq_rd_nxt  = oq_rd_r;
    oq_cnt_nxt = oq_cnt_r;
    if (v1_r) begin
      oq_wr_nxt = (oq_wr_r == pcc_pkg::OQ_PTR_W'(pcc_pkg::OQ_DEPTH - 1)) ? '0
                  : oq_wr_r + 1'b1;
    end
    if (oq_pop) begin
      oq_rd_nxt = (oq_rd_r == pcc_pkg::OQ_PTR_W'(pcc_pkg::OQ_DEPTH - 1)) ? '0
                  : oq_rd_r + 1'b1;
    end
    if (v1_r && !oq_pop) begin
      oq_cnt_nxt = oq_cnt_r + 1'b1;
    end else if (oq_pop && !v1_r) begin
      oq_cnt_nxt = oq_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      v1_r     <= v1_nxt;
      oq_wr_r  <= oq_wr_nxt;
      oq_rd_r  <= oq_rd_nxt;
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      oq_mem_r[oq_wr_r] <= drive;
    end
  end

endmodule
